// ===== hdl/rrts_pkg.sv =====
// Shared types, constants and codes for the round-robin task scheduler.
package rrts_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam logic [7:0]  TICK_PERIOD_RESET = 8'd10;
  localparam logic [15:0] FIRST_ID          = 16'd1;
  localparam logic [31:0] KILL_EXIT_CODE    = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    OP_CLEAR       = 4'd0,
    OP_ADOPT       = 4'd1,
    OP_ADD         = 4'd2,
    OP_YIELD       = 4'd3,
    OP_TICK        = 4'd4,
    OP_EXIT        = 4'd5,
    OP_KILL        = 4'd6,
    OP_WAIT        = 4'd7,
    OP_CHECK       = 4'd8,
    OP_TERM_OTHERS = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NO_SWITCH = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_PENDING   = 3'd4,
    STS_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    SLOT_INVALID    = 3'd0,
    SLOT_READY      = 3'd1,
    SLOT_RUNNING    = 3'd2,
    SLOT_BLOCKED    = 3'd3,
    SLOT_TERMINATED = 3'd4
  } slot_state_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_KILL, S_WAIT, S_TERM, S_WAKE, S_YINIT, S_YSCAN, S_FINISH
  } state_t;

  // Datapath action selected by the controller.
  typedef enum logic [3:0] {
    PH_NONE, PH_LOAD, PH_DECODE, PH_KILL, PH_WAIT, PH_TERM, PH_WAKE,
    PH_YINIT, PH_YSCAN, PH_FINISH
  } phase_t;

  typedef struct packed {
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       cur_valid;
    logic       scan_done;
    logic       kill_hit;
    logic       wait_hit;
    logic       wait_term;
    logic       yield_after;
    logic       count_le1;
    logic       y_done;
    logic       y_ready;
    logic       y_self;
    logic       flag;
    logic       out_busy;
  } stat_t;

endpackage

// ===== hdl/rrts_if.sv =====
// Command and result channel interfaces of the task scheduler.
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [31:0] stack_value;
  logic [15:0] target_id;
  logic signed [31:0] exit_value;

  modport source(output valid, op, stack_value, target_id, exit_value, input ready);
  modport sink(input valid, op, stack_value, target_id, exit_value, output ready);
endinterface

interface rrts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        switched;
  logic [31:0] next_stack;
  logic [3:0]  running_slot;
  logic [15:0] task_id;
  logic signed [31:0] result_code;
  logic        switch_pending;

  modport source(output valid, status, switched, next_stack, running_slot, task_id,
                 result_code, switch_pending, input ready);
  modport sink(input valid, status, switched, next_stack, running_slot, task_id,
               result_code, switch_pending, output ready);
endinterface

// ===== hdl/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler.
//
//   channel  direction  handshake       word
//   in_ch    input      valid/ready     op, stack_value, target_id, exit_value
//   out_ch   output     valid/ready     status .. switch_pending
//   cfg      input      cfg_we          tick_period
//
// One command at a time. A simple command passes through accept, decode and result
// load, and its word is registered in the result load step. Scans walk the table
// one slot per cycle: kill/wait/terminate and the wake pass each step through the
// occupied slots, a yield through the slots after the running one, so the worst
// command is a kill of the running task, which runs the kill scan, the wake pass
// and a yield before its word is loaded.
// Synchronous active-low reset empties the table; tick_period returns to 10.
// A new command is taken while a result still waits; a stalled result holds the
// next one in its final step.
module round_robin_task_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;
  logic [31:0]     result_code;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_ch.op),
    .in_stack_value     (in_ch.stack_value),
    .in_target_id       (in_ch.target_id),
    .in_exit_value      (32'(in_ch.exit_value)),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_switched       (out_ch.switched),
    .out_next_stack     (out_ch.next_stack),
    .out_running_slot   (out_ch.running_slot),
    .out_task_id        (out_ch.task_id),
    .out_result_code    (result_code),
    .out_switch_pending (out_ch.switch_pending)
  );

  assign out_ch.result_code = signed'(result_code);

endmodule

// ===== hdl/rrts_dp.sv =====
// Task table, scan counters and result register of the task scheduler.
module rrts_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rrts_pkg::cmd_t    cmd,
  output rrts_pkg::stat_t   stat,
  input  logic [3:0]        in_op,
  input  logic [31:0]       in_stack_value,
  input  logic [15:0]       in_target_id,
  input  logic [31:0]       in_exit_value,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic              out_switched,
  output logic [31:0]       out_next_stack,
  output logic [3:0]        out_running_slot,
  output logic [15:0]       out_task_id,
  output logic [31:0]       out_result_code,
  output logic              out_switch_pending
);

  localparam int SW = rrts_pkg::SLOT_W;
  localparam int CW = rrts_pkg::CNT_W;

  // Task table.
  logic [2:0]  slot_state_r [rrts_pkg::MAX_SLOTS];
  logic [15:0] slot_id_r    [rrts_pkg::MAX_SLOTS];
  logic [15:0] slot_wait_r  [rrts_pkg::MAX_SLOTS];
  logic [31:0] slot_exit_r  [rrts_pkg::MAX_SLOTS];
  logic [31:0] slot_stack_r [rrts_pkg::MAX_SLOTS];

  logic [SW-1:0] cur_r;
  logic [CW-1:0] count_r;
  logic [15:0]   next_id_r;
  logic [7:0]    tick_r;
  logic [7:0]    period_r;
  logic          flag_r;

  // Latched command word and working state.
  logic [3:0]    op_r;
  logic [31:0]   sp_r;
  logic [15:0]   tid_r;
  logic [31:0]   xv_r;
  logic [CW-1:0] idx_r;
  logic [SW-1:0] n_r;
  logic [CW-1:0] steps_r;
  logic [15:0]   wake_id_r;
  logic          yafter_r;
  logic [2:0]    status_r;
  logic          sw_r;
  logic [31:0]   stk_r;
  logic [31:0]   rc_r;
  logic          id_set_r;
  logic [15:0]   new_id_r;
  logic          out_valid_r;

  logic [SW-1:0] iw;
  logic [SW-1:0] cur_inc;
  logic [SW-1:0] n_inc;
  logic [15:0]   id_inc;
  logic [7:0]    tick_inc;
  logic          full;
  logic          cur_valid;
  logic          load_out;

  assign iw      = idx_r[SW-1:0];
  assign cur_inc = (CW'(cur_r) + CW'(1) == count_r) ? '0 : SW'(CW'(cur_r) + CW'(1));
  assign n_inc   = (CW'(n_r) + CW'(1) == count_r) ? '0 : SW'(CW'(n_r) + CW'(1));
  assign id_inc  = (next_id_r == 16'hFFFF) ? rrts_pkg::FIRST_ID : next_id_r + 16'd1;
  assign tick_inc = tick_r + 8'd1;
  assign full    = (count_r >= CW'(rrts_pkg::MAX_SLOTS));
  assign cur_valid = (count_r != '0) && (slot_state_r[cur_r] != rrts_pkg::SLOT_INVALID);
  assign load_out  = (cmd.phase == rrts_pkg::PH_FINISH) && !stat.out_busy;

  // Status toward the controller.
  always_comb begin
    stat.op          = op_r;
    stat.cur_valid   = cur_valid;
    stat.scan_done   = (idx_r >= count_r);
    stat.kill_hit    = (slot_state_r[iw] != rrts_pkg::SLOT_INVALID) &&
                       (slot_state_r[iw] != rrts_pkg::SLOT_TERMINATED) &&
                       (slot_id_r[iw] == tid_r);
    stat.wait_hit    = (slot_state_r[iw] != rrts_pkg::SLOT_INVALID) &&
                       (slot_id_r[iw] == tid_r);
    stat.wait_term   = (slot_state_r[iw] == rrts_pkg::SLOT_TERMINATED);
    stat.yield_after = yafter_r;
    stat.count_le1   = (count_r <= CW'(1));
    stat.y_done      = (steps_r >= count_r);
    stat.y_ready     = (slot_state_r[n_r] == rrts_pkg::SLOT_READY);
    stat.y_self      = (n_r == cur_r);
    stat.flag        = flag_r;
    stat.out_busy    = out_valid_r && !out_ready;
  end

  // Table updates, one action per cycle as the controller selects.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < rrts_pkg::MAX_SLOTS; k++) begin
        slot_state_r[k] <= rrts_pkg::SLOT_INVALID;
      end
      cur_r       <= '0;
      count_r     <= '0;
      next_id_r   <= rrts_pkg::FIRST_ID;
      tick_r      <= '0;
      flag_r      <= 1'b0;
      period_r    <= rrts_pkg::TICK_PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      case (cmd.phase)
        rrts_pkg::PH_LOAD: begin
          op_r     <= in_op;
          sp_r     <= in_stack_value;
          tid_r    <= in_target_id;
          xv_r     <= in_exit_value;
          status_r <= rrts_pkg::STS_OK;
          sw_r     <= 1'b0;
          stk_r    <= '0;
          rc_r     <= '0;
          id_set_r <= 1'b0;
          new_id_r <= '0;
          yafter_r <= 1'b0;
        end
        rrts_pkg::PH_DECODE: begin
          idx_r <= '0;
          case (op_r)
            rrts_pkg::OP_CLEAR: begin
              for (int k = 0; k < rrts_pkg::MAX_SLOTS; k++) begin
                slot_state_r[k] <= rrts_pkg::SLOT_INVALID;
              end
              cur_r     <= '0;
              count_r   <= '0;
              next_id_r <= rrts_pkg::FIRST_ID;
            end
            rrts_pkg::OP_ADOPT: begin
              if (full) begin
                status_r <= rrts_pkg::STS_FULL;
              end else begin
                new_id_r        <= next_id_r;
                id_set_r        <= 1'b1;
                next_id_r       <= id_inc;
                slot_state_r[0] <= rrts_pkg::SLOT_RUNNING;
                slot_id_r[0]    <= next_id_r;
                slot_wait_r[0]  <= '0;
                slot_exit_r[0]  <= '0;
                slot_stack_r[0] <= '0;
                count_r         <= CW'(1);
                cur_r           <= '0;
              end
            end
            rrts_pkg::OP_ADD: begin
              if (full) begin
                status_r <= rrts_pkg::STS_FULL;
              end else begin
                new_id_r  <= next_id_r;
                id_set_r  <= 1'b1;
                next_id_r <= id_inc;
                slot_state_r[count_r[SW-1:0]] <= rrts_pkg::SLOT_READY;
                slot_id_r[count_r[SW-1:0]]    <= next_id_r;
                slot_wait_r[count_r[SW-1:0]]  <= '0;
                slot_exit_r[count_r[SW-1:0]]  <= '0;
                slot_stack_r[count_r[SW-1:0]] <= sp_r;
                count_r <= count_r + CW'(1);
              end
            end
            rrts_pkg::OP_TICK: begin
              if (count_r > CW'(1)) begin
                if (tick_inc >= period_r) begin
                  tick_r <= '0;
                  flag_r <= 1'b1;
                end else begin
                  tick_r <= tick_inc;
                end
              end
            end
            rrts_pkg::OP_EXIT: begin
              if (!cur_valid) begin
                status_r <= rrts_pkg::STS_EMPTY;
              end else begin
                slot_state_r[cur_r] <= rrts_pkg::SLOT_TERMINATED;
                slot_exit_r[cur_r]  <= xv_r;
                wake_id_r           <= slot_id_r[cur_r];
                yafter_r            <= 1'b1;
              end
            end
            rrts_pkg::OP_KILL: begin
              status_r <= rrts_pkg::STS_NOT_FOUND;
            end
            rrts_pkg::OP_WAIT: begin
              status_r <= cur_valid ? rrts_pkg::STS_NOT_FOUND : rrts_pkg::STS_EMPTY;
            end
            rrts_pkg::OP_CHECK: begin
              if (flag_r) begin
                flag_r <= 1'b0;
              end else begin
                status_r <= rrts_pkg::STS_NO_SWITCH;
              end
            end
            rrts_pkg::OP_TERM_OTHERS: begin
              if (!cur_valid) begin
                status_r <= rrts_pkg::STS_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
        rrts_pkg::PH_KILL: begin
          if (!stat.scan_done) begin
            if (stat.kill_hit) begin
              slot_state_r[iw] <= rrts_pkg::SLOT_TERMINATED;
              slot_exit_r[iw]  <= rrts_pkg::KILL_EXIT_CODE;
              status_r         <= rrts_pkg::STS_OK;
              wake_id_r        <= tid_r;
              yafter_r         <= (iw == cur_r);
              idx_r            <= '0;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        rrts_pkg::PH_WAKE: begin
          if (!stat.scan_done) begin
            if (slot_state_r[iw] == rrts_pkg::SLOT_BLOCKED && slot_wait_r[iw] == wake_id_r) begin
              slot_state_r[iw] <= rrts_pkg::SLOT_READY;
              slot_wait_r[iw]  <= '0;
            end
            idx_r <= idx_r + CW'(1);
          end
        end
        rrts_pkg::PH_WAIT: begin
          if (!stat.scan_done) begin
            if (stat.wait_hit) begin
              if (stat.wait_term) begin
                rc_r     <= slot_exit_r[iw];
                status_r <= rrts_pkg::STS_OK;
              end else begin
                slot_state_r[cur_r] <= rrts_pkg::SLOT_BLOCKED;
                slot_wait_r[cur_r]  <= tid_r;
                status_r            <= rrts_pkg::STS_PENDING;
              end
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end
        end
        rrts_pkg::PH_TERM: begin
          if (!stat.scan_done) begin
            if (slot_state_r[iw] != rrts_pkg::SLOT_INVALID &&
                slot_id_r[iw] != slot_id_r[cur_r]) begin
              slot_state_r[iw] <= rrts_pkg::SLOT_TERMINATED;
            end
            idx_r <= idx_r + CW'(1);
          end
        end
        rrts_pkg::PH_YINIT: begin
          n_r     <= cur_inc;
          steps_r <= '0;
        end
        rrts_pkg::PH_YSCAN: begin
          if (!stat.y_done) begin
            if (stat.y_ready) begin
              if (!stat.y_self) begin
                if (slot_state_r[cur_r] == rrts_pkg::SLOT_RUNNING) begin
                  slot_state_r[cur_r] <= rrts_pkg::SLOT_READY;
                end
                if (slot_state_r[cur_r] != rrts_pkg::SLOT_INVALID) begin
                  slot_stack_r[cur_r] <= sp_r;
                end
                slot_state_r[n_r] <= rrts_pkg::SLOT_RUNNING;
                cur_r <= n_r;
                stk_r <= slot_stack_r[n_r];
                sw_r  <= 1'b1;
              end
            end else begin
              n_r     <= n_inc;
              steps_r <= steps_r + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase

      // Result register; a waiting word leaves when the sink takes it.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (op_r == rrts_pkg::OP_YIELD || op_r == rrts_pkg::OP_CHECK) begin
        out_status <= sw_r ? rrts_pkg::STS_OK : rrts_pkg::STS_NO_SWITCH;
      end else begin
        out_status <= status_r;
      end
      out_switched       <= sw_r;
      out_next_stack     <= stk_r;
      out_running_slot   <= 4'(cur_r);
      out_task_id        <= id_set_r ? new_id_r : (cur_valid ? slot_id_r[cur_r] : 16'd0);
      out_result_code    <= rc_r;
      out_switch_pending <= flag_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/rrts_ctrl.sv =====
// Sequencing state machine of the task scheduler.
module rrts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrts_pkg::stat_t stat,
  output rrts_pkg::cmd_t  cmd
);

  rrts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrts_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rrts_pkg::S_DECODE;
      end
      rrts_pkg::S_DECODE: begin
        case (stat.op)
          rrts_pkg::OP_YIELD: state_nxt = rrts_pkg::S_YINIT;
          rrts_pkg::OP_EXIT:
            state_nxt = stat.cur_valid ? rrts_pkg::S_WAKE : rrts_pkg::S_FINISH;
          rrts_pkg::OP_KILL: state_nxt = rrts_pkg::S_KILL;
          rrts_pkg::OP_WAIT:
            state_nxt = stat.cur_valid ? rrts_pkg::S_WAIT : rrts_pkg::S_FINISH;
          rrts_pkg::OP_CHECK:
            state_nxt = stat.flag ? rrts_pkg::S_YINIT : rrts_pkg::S_FINISH;
          rrts_pkg::OP_TERM_OTHERS:
            state_nxt = stat.cur_valid ? rrts_pkg::S_TERM : rrts_pkg::S_FINISH;
          default: state_nxt = rrts_pkg::S_FINISH;
        endcase
      end
      rrts_pkg::S_KILL: begin
        if (stat.scan_done) state_nxt = rrts_pkg::S_FINISH;
        else if (stat.kill_hit) state_nxt = rrts_pkg::S_WAKE;
      end
      rrts_pkg::S_WAKE: begin
        if (stat.scan_done)
          state_nxt = stat.yield_after ? rrts_pkg::S_YINIT : rrts_pkg::S_FINISH;
      end
      rrts_pkg::S_WAIT: begin
        if (stat.scan_done) state_nxt = rrts_pkg::S_FINISH;
        else if (stat.wait_hit)
          state_nxt = stat.wait_term ? rrts_pkg::S_FINISH : rrts_pkg::S_YINIT;
      end
      rrts_pkg::S_TERM: begin
        if (stat.scan_done) state_nxt = rrts_pkg::S_FINISH;
      end
      rrts_pkg::S_YINIT: begin
        state_nxt = stat.count_le1 ? rrts_pkg::S_FINISH : rrts_pkg::S_YSCAN;
      end
      rrts_pkg::S_YSCAN: begin
        if (stat.y_done || stat.y_ready) state_nxt = rrts_pkg::S_FINISH;
      end
      rrts_pkg::S_FINISH: begin
        if (!stat.out_busy) state_nxt = rrts_pkg::S_IDLE;
      end
      default: state_nxt = rrts_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = 1'b0;
    cmd.phase = rrts_pkg::PH_NONE;
    case (state_r)
      rrts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.phase = rrts_pkg::PH_LOAD;
      end
      rrts_pkg::S_DECODE: cmd.phase = rrts_pkg::PH_DECODE;
      rrts_pkg::S_KILL:   cmd.phase = rrts_pkg::PH_KILL;
      rrts_pkg::S_WAKE:   cmd.phase = rrts_pkg::PH_WAKE;
      rrts_pkg::S_WAIT:   cmd.phase = rrts_pkg::PH_WAIT;
      rrts_pkg::S_TERM:   cmd.phase = rrts_pkg::PH_TERM;
      rrts_pkg::S_YINIT:  cmd.phase = rrts_pkg::PH_YINIT;
      rrts_pkg::S_YSCAN:  cmd.phase = rrts_pkg::PH_YSCAN;
      rrts_pkg::S_FINISH: cmd.phase = rrts_pkg::PH_FINISH;
      default:            cmd.phase = rrts_pkg::PH_NONE;
    endcase
  end

endmodule
